FILE: sv/cone_visibility_test_top_defines.svh
// Assertion macros for the cone visibility test.
// Used by cone_visibility_test_top; expects clk and arst_n in scope.
`ifndef CONE_VISIBILITY_TEST_TOP_DEFINES_SVH
`define CONE_VISIBILITY_TEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define CVT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define CVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/cvt_pkg.sv
// Shared constants, types and helper functions for the cone visibility test.
// No dependencies.
`default_nettype none

package cvt_pkg;

	// Default sizing
	localparam int COORD_BITS_DEF    = 24;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int STAGE_LIMIT       = 24;

	// Field and register widths
	localparam int HALF_ANGLE_W = 16;
	localparam int RANGE_W      = 23;
	localparam int R2_W         = 2 * RANGE_W;
	localparam int CFG_DATA_W   = 23;
	localparam int CFG_INDEX_W  = 1;
	localparam int ANGLE_W      = 17;

	// Angle accumulator: degrees with 16 fraction bits
	localparam int Z_W        = 27;
	localparam int ROUND_BITS = 8;
	localparam int ANGLE_MAX  = 46080;

	localparam logic signed [Z_W-1:0] Z_HALF_TURN  = 27'sd11796480;
	localparam logic signed [Z_W-1:0] Z_ROUND_BIAS = 27'sd128;

	localparam logic [HALF_ANGLE_W-1:0] HALF_ANGLE_RESET = 16'd11520;
	localparam logic [RANGE_W-1:0]      RANGE_RESET      = '0;

	// atan(2^-i) in degrees, scaled by 65536 and rounded
	localparam logic signed [Z_W-1:0] ATAN_DEG16 [STAGE_LIMIT] = '{
		27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
		27'sd234379,  27'sd117288,  27'sd58666,  27'sd29335,
		27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
		27'sd917,     27'sd458,     27'sd229,    27'sd115,
		27'sd57,      27'sd29,      27'sd14,     27'sd7,
		27'sd4,       27'sd2,       27'sd1,      27'sd0
	};

	// Register map
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HALF_ANGLE  = 1'b0,
		CFG_RANGE_LIMIT = 1'b1
	} cfg_index_t;

	// Per-item side information carried along the pipeline
	typedef struct packed {
		logic pass;   // sight and range checks passed
		logic zero;   // one of the vectors is (0,0)
	} cvt_meta_t;

	// Right shift applied to the products so they fit the datapath
	function automatic int pre_shift(input int cb);
		return (2 * cb > 58) ? (2 * cb - 58) : 0;
	endfunction

	// Width of the CORDIC x/y datapath: shifted product plus sum, negate and gain
	function automatic int cordic_width(input int cb);
		return 2 * cb - pre_shift(cb) + 3;
	endfunction

endpackage

`default_nettype wire

FILE: sv/cvt_if.sv
// Valid/ready channel interfaces for the cone visibility test.
// Depends on cvt_pkg.
`default_nettype none

// Input channel: one beat per vector pair
interface cvt_in_if #(
	parameter int COORD_BITS = cvt_pkg::COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] facing_x;
	logic signed [COORD_BITS-1:0] facing_y;
	logic signed [COORD_BITS-1:0] target_x;
	logic signed [COORD_BITS-1:0] target_y;
	logic                         has_sight;

	modport source (
		output valid, facing_x, facing_y, target_x, target_y, has_sight,
		input  ready
	);
	modport sink (
		input  valid, facing_x, facing_y, target_x, target_y, has_sight,
		output ready
	);
endinterface

// Result channel: one beat per item
interface cvt_out_if ();
	logic                               valid;
	logic                               ready;
	logic                               visible;
	logic signed [cvt_pkg::ANGLE_W-1:0] signed_angle;

	modport source (
		output valid, visible, signed_angle,
		input  ready
	);
	modport sink (
		input  valid, visible, signed_angle,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/cone_visibility_test_top.sv
// Cone visibility test, top level: config registers, front end, CORDIC cell chain, back end.
// Depends on cvt_pkg, cvt_if, cvt_front, cvt_cordic_cell, cvt_back and the defines header.
// Takes one vector pair per clock and returns one result per item, in order. Each item passes
// through three front stages (products, cross/dot, quadrant fold), one register per CORDIC
// cell and one result register. Throughput is one item per cycle, and the pipeline only
// stalls when the result channel holds back a beat with every stage full.
// The user must write half_angle and range_limit through the cfg port only while no item
// is in flight; the block does not enforce this.
`default_nettype none

`include "cone_visibility_test_top_defines.svh"

module cone_visibility_test_top #(
	parameter int COORD_BITS    = cvt_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STAGES = cvt_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [cvt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [cvt_pkg::CFG_DATA_W-1:0]   cfg_data,
	cvt_in_if.sink                                in_ch,
	cvt_out_if.source                             out_ch
);

	localparam int W = cvt_pkg::cordic_width(COORD_BITS);

	// Configuration registers and the squared range
	logic [cvt_pkg::HALF_ANGLE_W-1:0] half_angle_q;
	logic [cvt_pkg::RANGE_W-1:0]      range_limit_q;
	logic [cvt_pkg::R2_W-1:0]         r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_angle_q  <= cvt_pkg::HALF_ANGLE_RESET;
			range_limit_q <= cvt_pkg::RANGE_RESET;
			r2_q          <= '0;
		end else begin
			r2_q <= range_limit_q * range_limit_q;
			if (cfg_we) begin
				case (cvt_pkg::cfg_index_t'(cfg_index))
					cvt_pkg::CFG_HALF_ANGLE: begin
						half_angle_q <= cfg_data[cvt_pkg::HALF_ANGLE_W-1:0];
					end
					cvt_pkg::CFG_RANGE_LIMIT: begin
						range_limit_q <= cfg_data[cvt_pkg::RANGE_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Links between the front end, the cells and the back end
	logic                           ch_valid [0:CORDIC_STAGES];
	logic                           ch_ready [0:CORDIC_STAGES];
	logic signed [W-1:0]            ch_x     [0:CORDIC_STAGES];
	logic signed [W-1:0]            ch_y     [0:CORDIC_STAGES];
	logic signed [cvt_pkg::Z_W-1:0] ch_z     [0:CORDIC_STAGES];
	cvt_pkg::cvt_meta_t             ch_meta  [0:CORDIC_STAGES];

	cvt_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.r2       (r2_q),
		.dn_valid (ch_valid[0]),
		.dn_ready (ch_ready[0]),
		.dn_x     (ch_x[0]),
		.dn_y     (ch_y[0]),
		.dn_z     (ch_z[0]),
		.dn_meta  (ch_meta[0])
	);

	// CORDIC cell chain, one micro-rotation per cell
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		cvt_cordic_cell #(
			.W     (W),
			.STAGE (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[g]),
			.up_ready (ch_ready[g]),
			.up_x     (ch_x[g]),
			.up_y     (ch_y[g]),
			.up_z     (ch_z[g]),
			.up_meta  (ch_meta[g]),
			.dn_valid (ch_valid[g+1]),
			.dn_ready (ch_ready[g+1]),
			.dn_x     (ch_x[g+1]),
			.dn_y     (ch_y[g+1]),
			.dn_z     (ch_z[g+1]),
			.dn_meta  (ch_meta[g+1])
		);
	end

	cvt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (ch_valid[CORDIC_STAGES]),
		.up_ready   (ch_ready[CORDIC_STAGES]),
		.up_z       (ch_z[CORDIC_STAGES]),
		.up_meta    (ch_meta[CORDIC_STAGES]),
		.half_angle (half_angle_q),
		.out_ch     (out_ch)
	);

	// Checks
	logic signed [cvt_pkg::ANGLE_W-1:0] cone_lim;

	assign cone_lim = $signed({1'b0, half_angle_q});

	`CVT_ASSERT_SAME(a_stall_from_output, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output backpressure")
	`CVT_ASSERT_SAME(a_visible_in_cone, out_ch.valid && out_ch.visible, out_ch.signed_angle <= cone_lim && out_ch.signed_angle >= -cone_lim, "visible result outside the cone")
	`CVT_ASSERT_NEXT(a_full_stays_full, out_ch.valid && !out_ch.ready && !in_ch.ready, !in_ch.ready || out_ch.ready, "full pipeline drained without an output beat")

endmodule

`default_nettype wire

FILE: sv/cvt_front.sv
// Front end: products, cross/dot, range check and quadrant pre-rotation.
// Depends on cvt_pkg and cvt_if; feeds the first CORDIC cell.
`default_nettype none

module cvt_front #(
	parameter int COORD_BITS = cvt_pkg::COORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	cvt_in_if.sink                                  in_ch,
	input  wire logic [cvt_pkg::R2_W-1:0]           r2,
	output logic                                    dn_valid,
	input  wire logic                               dn_ready,
	output logic signed [cvt_pkg::cordic_width(COORD_BITS)-1:0] dn_x,
	output logic signed [cvt_pkg::cordic_width(COORD_BITS)-1:0] dn_y,
	output logic signed [cvt_pkg::Z_W-1:0]          dn_z,
	output cvt_pkg::cvt_meta_t                      dn_meta
);

	localparam int PROD_W = 2 * COORD_BITS;
	localparam int PRE    = cvt_pkg::pre_shift(COORD_BITS);
	localparam int P_W    = PROD_W - PRE;
	localparam int W      = cvt_pkg::cordic_width(COORD_BITS);
	localparam int SQ_W   = PROD_W - 1;
	localparam int D2_W   = PROD_W;
	localparam int CMP_W  = (D2_W > cvt_pkg::R2_W) ? D2_W : cvt_pkg::R2_W;

	// Stage enables: a stage loads when it is empty or its content moves on
	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	assign en_s3       = !valid_s3 || dn_ready;
	assign en_s2       = !valid_s2 || en_s3;
	assign en_s1       = !valid_s1 || en_s2;
	assign in_ch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_ch.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: the six products and the zero-vector test
	logic signed [PROD_W-1:0] p_fxty_s1, p_fytx_s1, p_fxtx_s1, p_fyty_s1;
	logic signed [PROD_W-1:0] sq_tx_full, sq_ty_full;
	logic [SQ_W-1:0]          sq_tx_s1, sq_ty_s1;
	logic                     zero_s1, sight_s1;

	assign sq_tx_full = in_ch.target_x * in_ch.target_x;
	assign sq_ty_full = in_ch.target_y * in_ch.target_y;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_fxty_s1 <= in_ch.facing_x * in_ch.target_y;
			p_fytx_s1 <= in_ch.facing_y * in_ch.target_x;
			p_fxtx_s1 <= in_ch.facing_x * in_ch.target_x;
			p_fyty_s1 <= in_ch.facing_y * in_ch.target_y;
			sq_tx_s1  <= sq_tx_full[SQ_W-1:0];
			sq_ty_s1  <= sq_ty_full[SQ_W-1:0];
			zero_s1   <= (in_ch.facing_x == '0 && in_ch.facing_y == '0) ||
			             (in_ch.target_x == '0 && in_ch.target_y == '0);
			sight_s1  <= in_ch.has_sight;
		end
	end

	// Stage 2: floor-shift products, form cross/dot, exact range compare
	logic signed [PROD_W-1:0] sh_fxty, sh_fytx, sh_fxtx, sh_fyty;
	logic signed [W-1:0]      cross_w, dot_w;
	logic [D2_W-1:0]          d2;
	logic                     too_far;
	logic signed [W-1:0]      x_s2, y_s2;
	cvt_pkg::cvt_meta_t       meta_s2;

	assign sh_fxty = p_fxty_s1 >>> PRE;
	assign sh_fytx = p_fytx_s1 >>> PRE;
	assign sh_fxtx = p_fxtx_s1 >>> PRE;
	assign sh_fyty = p_fyty_s1 >>> PRE;

	assign cross_w = W'($signed(sh_fxty[P_W-1:0])) - W'($signed(sh_fytx[P_W-1:0]));
	assign dot_w   = W'($signed(sh_fxtx[P_W-1:0])) + W'($signed(sh_fyty[P_W-1:0]));

	assign d2      = D2_W'(sq_tx_s1) + D2_W'(sq_ty_s1);
	assign too_far = (r2 != '0) && (CMP_W'(d2) > CMP_W'(r2));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			x_s2         <= dot_w;
			y_s2         <= cross_w;
			meta_s2.zero <= zero_s1;
			meta_s2.pass <= sight_s1 && !too_far;
		end
	end

	// Stage 3: fold the left half-plane onto the right, preset z to +/-180
	logic                        left_half;
	logic signed [W-1:0]         x_s3, y_s3;
	logic signed [cvt_pkg::Z_W-1:0] z_s3;
	cvt_pkg::cvt_meta_t          meta_s3;

	assign left_half = x_s2[W-1];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3    <= left_half ? -x_s2 : x_s2;
			y_s3    <= left_half ? -y_s2 : y_s2;
			z_s3    <= !left_half ? '0 :
			           (y_s2[W-1] ? -cvt_pkg::Z_HALF_TURN : cvt_pkg::Z_HALF_TURN);
			meta_s3 <= meta_s2;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_x     = x_s3;
	assign dn_y     = y_s3;
	assign dn_z     = z_s3;
	assign dn_meta  = meta_s3;

endmodule

`default_nettype wire

FILE: sv/cvt_cordic_cell.sv
// One vectoring CORDIC cell: a fixed micro-rotation and its register.
// Depends on cvt_pkg; chained by the top level.
`default_nettype none

module cvt_cordic_cell #(
	parameter int W     = cvt_pkg::cordic_width(cvt_pkg::COORD_BITS_DEF),
	parameter int STAGE = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              up_valid,
	output logic                                   up_ready,
	input  wire logic signed [W-1:0]               up_x,
	input  wire logic signed [W-1:0]               up_y,
	input  wire logic signed [cvt_pkg::Z_W-1:0]    up_z,
	input  wire cvt_pkg::cvt_meta_t                up_meta,
	output logic                                   dn_valid,
	input  wire logic                              dn_ready,
	output logic signed [W-1:0]                    dn_x,
	output logic signed [W-1:0]                    dn_y,
	output logic signed [cvt_pkg::Z_W-1:0]         dn_z,
	output cvt_pkg::cvt_meta_t                     dn_meta
);

	logic                           en;
	logic                           valid_q;
	logic signed [W-1:0]            x_q, y_q;
	logic signed [cvt_pkg::Z_W-1:0] z_q;
	cvt_pkg::cvt_meta_t             meta_q;

	// Rotate toward y = 0; sign of y picks the direction
	logic                pos;
	logic signed [W-1:0] y_sh, x_sh;

	assign pos  = !up_y[W-1];
	assign y_sh = up_y >>> STAGE;
	assign x_sh = up_x >>> STAGE;

	assign en       = !valid_q || dn_ready;
	assign up_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= pos ? (up_x + y_sh) : (up_x - y_sh);
			y_q    <= pos ? (up_y - x_sh) : (up_y + x_sh);
			z_q    <= pos ? (up_z + cvt_pkg::ATAN_DEG16[STAGE])
			              : (up_z - cvt_pkg::ATAN_DEG16[STAGE]);
			meta_q <= up_meta;
		end
	end

	assign dn_valid = valid_q;
	assign dn_x     = x_q;
	assign dn_y     = y_q;
	assign dn_z     = z_q;
	assign dn_meta  = meta_q;

endmodule

`default_nettype wire

FILE: sv/cvt_back.sv
// Back end: round and clamp the angle, cone check, result register.
// Depends on cvt_pkg and cvt_if; fed by the last CORDIC cell.
`default_nettype none

module cvt_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               up_valid,
	output logic                                    up_ready,
	input  wire logic signed [cvt_pkg::Z_W-1:0]     up_z,
	input  wire cvt_pkg::cvt_meta_t                 up_meta,
	input  wire logic [cvt_pkg::HALF_ANGLE_W-1:0]   half_angle,
	cvt_out_if.source                               out_ch
);

	localparam int RW = cvt_pkg::Z_W - cvt_pkg::ROUND_BITS;
	localparam int AW = cvt_pkg::ANGLE_W;

	localparam logic signed [RW-1:0] R_MAX = RW'(cvt_pkg::ANGLE_MAX);
	localparam logic signed [AW-1:0] A_MAX = AW'(cvt_pkg::ANGLE_MAX);

	// Round to Q8.8, clamp, force zero for a null vector
	logic signed [cvt_pkg::Z_W-1:0] z_bias, z_sh;
	logic signed [RW-1:0]           rounded;
	logic signed [AW-1:0]           angle;
	logic [AW-1:0]                  mag;
	logic                           in_cone;

	assign z_bias  = up_z + cvt_pkg::Z_ROUND_BIAS;
	assign z_sh    = z_bias >>> cvt_pkg::ROUND_BITS;
	assign rounded = z_sh[RW-1:0];

	always_comb begin
		if (up_meta.zero) begin
			angle = '0;
		end else if (rounded > R_MAX) begin
			angle = A_MAX;
		end else if (rounded < -R_MAX) begin
			angle = -A_MAX;
		end else begin
			angle = rounded[AW-1:0];
		end
	end

	assign mag     = angle[AW-1] ? AW'(-angle) : AW'(angle);
	assign in_cone = mag <= AW'(half_angle);

	// Result register
	logic                 en;
	logic                 valid_q;
	logic                 visible_q;
	logic signed [AW-1:0] angle_q;

	assign en       = !valid_q || out_ch.ready;
	assign up_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			visible_q <= up_meta.pass && in_cone;
			angle_q   <= angle;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.visible      = visible_q;
	assign out_ch.signed_angle = angle_q;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for cone_visibility_test_top: random and directed vector pairs go
// through a valid/ready driver, and each result beat is checked against an in-bench model.
// Depends on cvt_pkg, cvt_if and the cone_visibility_test_top RTL.

module testbench;

	localparam int COORD_W   = cvt_pkg::COORD_BITS_DEF;
	localparam int STAGES    = cvt_pkg::CORDIC_STAGES_DEF;
	localparam int HOLD_LEN  = 200;
	localparam longint TURN_HALF = 64'sd11796480;   // 180 degrees, 16 fraction bits

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = 24'h7FFFFF;
	localparam coord_t COORD_MIN = 24'h800000;

	// atan(2^-k) in degrees, 16 fraction bits
	localparam longint ATAN_Q16 [16] = '{
		2949120, 1740967, 919879, 466945, 234379, 117288, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	typedef struct packed {
		coord_t facing_x;
		coord_t facing_y;
		coord_t target_x;
		coord_t target_y;
		logic   has_sight;
	} vec_pair_t;

	typedef struct packed {
		logic                               visible;
		logic signed [cvt_pkg::ANGLE_W-1:0] angle;
	} verdict_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_we;
	logic [cvt_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [cvt_pkg::CFG_DATA_W-1:0]  cfg_data;

	cvt_in_if #(.COORD_BITS(COORD_W)) in_ch ();
	cvt_out_if                        out_ch ();

	cone_visibility_test_top #(
		.COORD_BITS    (COORD_W),
		.CORDIC_STAGES (STAGES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Bench copy of the registers
	logic [cvt_pkg::HALF_ANGLE_W-1:0] half_ang  = cvt_pkg::HALF_ANGLE_RESET;
	logic [cvt_pkg::RANGE_W-1:0]      rng_limit = cvt_pkg::RANGE_RESET;

	vec_pair_t pair_queue[$];
	verdict_t  pending_verdicts[$];
	vec_pair_t next_pair;
	vec_pair_t seen_pair;
	verdict_t  want;

	bit src_idle_en = 1'b1;
	bit snk_idle_en = 1'b1;
	int src_gap;
	int rdy_gap;
	int hold_left;
	int holds_asked  = 0;
	int holds_served;
	int pairs_sent   = 0;
	int results_seen = 0;
	int visible_seen = 0;
	int stall_cycles = 0;
	int settings_run = 1;
	int errors       = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

	// Angle from facing to target by vectoring CORDIC, then the sight/range/cone checks
	function automatic verdict_t visibility_of(input vec_pair_t p);
		longint fx, fy, tx, ty, x, y, z, nx, ny, mag, d2, r2;
		verdict_t v;
		fx = p.facing_x;
		fy = p.facing_y;
		tx = p.target_x;
		ty = p.target_y;
		z  = 0;
		if (!((fx == 0 && fy == 0) || (tx == 0 && ty == 0))) begin
			y = fx * ty - fy * tx;
			x = fx * tx + fy * ty;
			// fold the left half plane onto the right one
			if (x < 0) begin
				z = (y >= 0) ? TURN_HALF : -TURN_HALF;
				x = -x;
				y = -y;
			end
			for (int k = 0; k < STAGES; k++) begin
				if (y >= 0) begin
					nx = x + (y >>> k);
					ny = y - (x >>> k);
					z  = z + ATAN_Q16[k];
				end else begin
					nx = x - (y >>> k);
					ny = y + (x >>> k);
					z  = z - ATAN_Q16[k];
				end
				x = nx;
				y = ny;
			end
			z = (z + 128) >>> cvt_pkg::ROUND_BITS;
			if (z > cvt_pkg::ANGLE_MAX)
				z = cvt_pkg::ANGLE_MAX;
			if (z < -cvt_pkg::ANGLE_MAX)
				z = -cvt_pkg::ANGLE_MAX;
		end
		mag = (z < 0) ? -z : z;
		v.visible = p.has_sight;
		if (v.visible && rng_limit != 0) begin
			d2 = tx * tx + ty * ty;
			r2 = longint'(rng_limit) * longint'(rng_limit);
			if (d2 > r2)
				v.visible = 1'b0;
		end
		if (v.visible && mag > longint'(half_ang))
			v.visible = 1'b0;
		v.angle = z[cvt_pkg::ANGLE_W-1:0];
		return v;
	endfunction

	function automatic coord_t jitter(input int span);
		return coord_t'(int'($urandom_range(0, 2 * span - 1)) - span);
	endfunction

	function automatic coord_t corner_coord();
		case ($urandom_range(0, 5))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3: return 1;
			4: return -1;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Mix of full-scale, small, near-facing, opposite, zero-vector and corner pairs
	function automatic vec_pair_t random_pair();
		vec_pair_t p;
		p.has_sight = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				p.facing_x = coord_t'($urandom);
				p.facing_y = coord_t'($urandom);
				p.target_x = coord_t'($urandom);
				p.target_y = coord_t'($urandom);
			end
			3, 4, 5: begin
				p.facing_x = jitter(2048);
				p.facing_y = jitter(2048);
				p.target_x = jitter(2048);
				p.target_y = jitter(2048);
			end
			6: begin
				p.facing_x = jitter(4096);
				p.facing_y = jitter(4096);
				p.target_x = p.facing_x + jitter(1024);
				p.target_y = p.facing_y + jitter(1024);
			end
			7: begin
				p.facing_x = jitter(65536);
				p.facing_y = jitter(65536);
				p.target_x = jitter(65536);
				p.target_y = jitter(65536);
				if ($urandom_range(0, 1)) begin
					p.facing_x = '0;
					p.facing_y = '0;
				end else begin
					p.target_x = '0;
					p.target_y = '0;
				end
			end
			8: begin
				p.facing_x = corner_coord();
				p.facing_y = corner_coord();
				p.target_x = corner_coord();
				p.target_y = corner_coord();
			end
			default: begin
				p.facing_x = jitter(4096);
				p.facing_y = jitter(4096);
				p.target_x = -p.facing_x + jitter(256);
				p.target_y = -p.facing_y + jitter(256);
			end
		endcase
		return p;
	endfunction

	task automatic queue_aim(input coord_t fx, input coord_t fy, input coord_t tx,
			input coord_t ty, input logic sight);
		pair_queue.push_back({fx, fy, tx, ty, sight});
	endtask

	task automatic queue_random(input int n);
		repeat (n) pair_queue.push_back(random_pair());
	endtask

	// Wait until nothing is queued, offered or outstanding
	task automatic drain();
		while (pair_queue.size() != 0 || in_ch.valid || pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cvt_pkg::cfg_index_t idx,
			input logic [cvt_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cvt_pkg::CFG_HALF_ANGLE:  half_ang  = val[cvt_pkg::HALF_ANGLE_W-1:0];
			cvt_pkg::CFG_RANGE_LIMIT: rng_limit = val[cvt_pkg::RANGE_W-1:0];
			default: ;
		endcase
	endtask

	// Reprogram both registers once the pipeline is empty
	task automatic new_setting(input logic [cvt_pkg::CFG_DATA_W-1:0] half_val,
			input logic [cvt_pkg::CFG_DATA_W-1:0] range_val, input bit idle_on);
		drain();
		write_reg(cvt_pkg::CFG_HALF_ANGLE, half_val);
		write_reg(cvt_pkg::CFG_RANGE_LIMIT, range_val);
		src_idle_en = idle_on;
		snk_idle_en = idle_on;
		settings_run++;
	endtask

	// Stimulus and phase control
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 45 degree cone, unlimited range
		queue_aim(256, 0, 256, 0, 1'b1);
		queue_aim(0, 0, 1000, -5, 1'b1);
		queue_aim(5, 5, 0, 0, 1'b1);
		queue_aim(0, 0, 0, 0, 1'b1);
		queue_aim(256, 0, 0, 256, 1'b1);
		queue_aim(256, 0, 0, -256, 1'b1);
		queue_aim(256, 0, -256, 0, 1'b1);
		queue_aim(256, 0, -256, -1, 1'b1);
		queue_aim(256, 0, 256, 256, 1'b1);
		queue_aim(256, 0, 256, -256, 1'b1);
		queue_aim(256, 0, 256, 0, 1'b0);
		queue_aim(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
		queue_aim(COORD_MIN, 0, COORD_MIN, 1, 1'b1);
		queue_aim(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
		queue_aim(1, 0, 0, 1, 1'b1);
		queue_aim(-1, -1, 1, -1, 1'b1);
		queue_aim(0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
		queue_aim(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
		queue_random(150);

		// zero-width cone, range boundary exactly on the limit
		new_setting(0, 1000, 1'b1);
		queue_aim(600, 800, 600, 800, 1'b1);
		queue_aim(600, 800, 600, 801, 1'b1);
		queue_aim(1000, 0, 1000, 0, 1'b1);
		queue_aim(1000, 0, 1001, 0, 1'b1);
		queue_aim(-1, 0, -1000, 0, 1'b1);
		queue_random(150);

		// widest cone, largest range, no idling
		new_setting(cvt_pkg::ANGLE_MAX, 23'h7FFFFF, 1'b0);
		queue_random(150);

		// half-angle beyond 180 degrees, tiny range
		new_setting(16'hFFFF, 1, 1'b1);
		queue_random(150);

		// random setting, junk above the half-angle field; long output hold, then a pause
		new_setting({7'($urandom), 16'($urandom_range(0, cvt_pkg::ANGLE_MAX))},
			$urandom_range(1, 5000), 1'b1);
		queue_random(75);
		holds_asked++;
		drain();
		queue_random(75);

		new_setting($urandom_range(0, cvt_pkg::ANGLE_MAX), 0, 1'b1);
		queue_random(150);

		// tail of the run: back-to-back traffic, no idling
		new_setting(cvt_pkg::HALF_ANGLE_RESET, $urandom_range(1, 23'h7FFFFF), 1'b0);
		queue_random(250);

		drain();
		repeat (4 + STAGES + 8) @(posedge clk);
		$display("tb: %0d vector pairs sent, %0d results checked (%0d visible), %0d settings",
			pairs_sent, results_seen, visible_seen, settings_run);
		$display("tb: input held off by backpressure for %0d cycles, %0d mismatches",
			stall_cycles, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Input driver: predicts each accepted beat, then offers the next pair or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid     <= 1'b0;
			in_ch.facing_x  <= '0;
			in_ch.facing_y  <= '0;
			in_ch.target_x  <= '0;
			in_ch.target_y  <= '0;
			in_ch.has_sight <= 1'b0;
			src_gap         <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				seen_pair = {in_ch.facing_x, in_ch.facing_y, in_ch.target_x,
					in_ch.target_y, in_ch.has_sight};
				pending_verdicts.push_back(visibility_of(seen_pair));
				pairs_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap > 0) begin
					src_gap     <= src_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
					src_gap     <= $urandom_range(0, 11);
					in_ch.valid <= 1'b0;
				end else if (pair_queue.size() > 0) begin
					next_pair        = pair_queue.pop_front();
					in_ch.valid     <= 1'b1;
					in_ch.facing_x  <= next_pair.facing_x;
					in_ch.facing_y  <= next_pair.facing_y;
					in_ch.target_x  <= next_pair.target_x;
					in_ch.target_y  <= next_pair.target_y;
					in_ch.has_sight <= next_pair.has_sight;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result-side ready: random bursts of backpressure plus requested long holds
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rdy_gap      <= 0;
			hold_left    <= 0;
			holds_served <= 0;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_LEN;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (rdy_gap > 0) begin
			rdy_gap      <= rdy_gap - 1;
			out_ch.ready <= 1'b0;
		end else if (snk_idle_en && $urandom_range(0, 9) == 0) begin
			rdy_gap      <= $urandom_range(0, 11);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Result checker: each beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !in_ch.ready)
				stall_cycles++;
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (pending_verdicts.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("tb: result beat with nothing outstanding: visible=%0d angle=%0d",
							out_ch.visible, out_ch.signed_angle);
				end else begin
					want = pending_verdicts.pop_front();
					if (want.visible)
						visible_seen++;
					if (out_ch.visible !== want.visible || out_ch.signed_angle !== want.angle) begin
						errors++;
						if (errors <= 10)
							$display("tb: mismatch: expected visible=%0d angle=%0d, got visible=%0d angle=%0d",
								want.visible, want.angle, out_ch.visible, out_ch.signed_angle);
					end
				end
			end
		end
	end

endmodule
